// ----- sv/sidach_pkg.sv -----
// types, constants and the id mask function shared by the access code hash block
// no dependencies
package sidach_pkg;

	typedef logic [31:0] word_t;

	// request to the shared multiplier
	typedef struct packed {
		logic  en;
		word_t a;
		word_t b;
	} mul_req_t;

	localparam int ByteW  = 8;
	localparam int WordW  = 32;
	localparam int TdataW = ByteW + WordW;

	localparam word_t FwdEven = 32'd9;
	localparam word_t FwdOdd  = 32'd17;
	localparam word_t WgtEven = 32'd17;
	localparam word_t WgtOdd  = 32'd33;

	function automatic word_t id_mask(input word_t id);
		logic [7:0] b0, b1, b2, b3, hi, lo;
		b0 = id[7:0];
		b1 = id[15:8];
		b2 = id[23:16];
		b3 = id[31:24];
		hi = (b2 == 8'h00) ? ~b1 : b2;
		lo = (b3 == 8'h00) ? ~b0 : b3;
		return {b0, hi, b1, lo};
	endfunction

endpackage

// ----- sv/sidach_mul.sv -----
// shared 32 x 32 multiplier keeping the low word, product registered
// depends on sidach_pkg
module sidach_mul (
	input  logic                 clk,
	input  sidach_pkg::mul_req_t req,
	output sidach_pkg::word_t    p
);

	sidach_pkg::word_t p_q;

	always_ff @(posedge clk) begin
		if (req.en) begin
			p_q <= sidach_pkg::word_t'(req.a * req.b);
		end
	end

	assign p = p_q;

endmodule

// ----- sv/sidach_seq.sv -----
// sequencer and hash state: drives the shared multiplier per byte and for the final code
// depends on sidach_pkg
module sidach_seq (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 start,
	input  logic [7:0]           text_byte,
	input  logic                 has_byte,
	input  logic                 last,
	input  sidach_pkg::word_t    id,
	input  logic                 out_free,
	input  sidach_pkg::word_t    mul_p,
	output sidach_pkg::mul_req_t mul_req,
	output logic                 idle,
	output logic                 done,
	output sidach_pkg::word_t    code
);

	localparam logic [2:0] S_IDLE  = 3'd0;
	localparam logic [2:0] S_FWD   = 3'd1;
	localparam logic [2:0] S_WSUM  = 3'd2;
	localparam logic [2:0] S_WGT   = 3'd3;
	localparam logic [2:0] S_WEND  = 3'd4;
	localparam logic [2:0] S_CODE1 = 3'd5;
	localparam logic [2:0] S_CODE2 = 3'd6;
	localparam logic [2:0] S_CODE3 = 3'd7;

	logic [2:0]        state_q;
	logic [7:0]        byte_q;
	logic              last_q;
	sidach_pkg::word_t id_q;
	sidach_pkg::word_t fwd_q;
	sidach_pkg::word_t wsum_q;
	sidach_pkg::word_t weight_q;
	logic              odd_q;

	sidach_pkg::word_t c_ext;
	sidach_pkg::word_t mask;

	assign c_ext = {{(sidach_pkg::WordW - sidach_pkg::ByteW){byte_q[7]}}, byte_q};
	assign mask  = sidach_pkg::id_mask(id_q);

	always_comb begin
		mul_req = '0;
		unique case (state_q)
			S_FWD: begin
				mul_req.en = 1'b1;
				mul_req.a  = fwd_q;
				mul_req.b  = odd_q ? sidach_pkg::FwdOdd : sidach_pkg::FwdEven;
			end
			S_WSUM: begin
				mul_req.en = 1'b1;
				mul_req.a  = c_ext;
				mul_req.b  = weight_q;
			end
			S_WGT: begin
				mul_req.en = 1'b1;
				mul_req.a  = weight_q;
				mul_req.b  = odd_q ? sidach_pkg::WgtOdd : sidach_pkg::WgtEven;
			end
			S_CODE1: begin
				mul_req.en = 1'b1;
				mul_req.a  = (wsum_q ^ mask) + (fwd_q | id_q);
				mul_req.b  = fwd_q | mask;
			end
			S_CODE2: begin
				mul_req.en = 1'b1;
				mul_req.a  = mul_p;
				mul_req.b  = wsum_q ^ id_q;
			end
			default: begin
				mul_req = '0;
			end
		endcase
	end

	assign idle = (state_q == S_IDLE);
	assign done = (state_q == S_CODE3) && out_free;
	assign code = mul_p;

	// item payload
	always_ff @(posedge clk) begin
		if (start) begin
			byte_q <= text_byte;
			last_q <= last;
			id_q   <= id;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= S_IDLE;
			fwd_q    <= '0;
			wsum_q   <= '0;
			weight_q <= 32'd1;
			odd_q    <= 1'b0;
		end else begin
			unique case (state_q)
				S_IDLE: begin
					if (start) begin
						if (has_byte) begin
							state_q <= S_FWD;
						end else if (last) begin
							state_q <= S_CODE1;
						end
					end
				end
				S_FWD: begin
					state_q <= S_WSUM;
				end
				S_WSUM: begin
					fwd_q   <= mul_p + c_ext;
					state_q <= S_WGT;
				end
				S_WGT: begin
					wsum_q  <= wsum_q + mul_p;
					state_q <= S_WEND;
				end
				S_WEND: begin
					weight_q <= mul_p;
					odd_q    <= ~odd_q;
					state_q  <= last_q ? S_CODE1 : S_IDLE;
				end
				S_CODE1: begin
					state_q <= S_CODE2;
				end
				S_CODE2: begin
					state_q <= S_CODE3;
				end
				S_CODE3: begin
					if (out_free) begin
						fwd_q    <= '0;
						wsum_q   <= '0;
						weight_q <= 32'd1;
						odd_q    <= 1'b0;
						state_q  <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

endmodule

// ----- sv/string_id_access_code_hash_top.sv -----
// top level of the string and id access code hash: stream ports and output register
// depends on sidach_pkg, sidach_seq, sidach_mul
//
// channel    dir  width  contents
// s_axis     in   40+1+1 text byte and id, has_byte flag, end of string
// m_axis     out  32     access code
//
// an empty request stays in S_IDLE; a request with a byte runs S_FWD to S_WEND (one shared
// multiplier, three products per byte), and the end of a string adds the two code products.
// s_axis_tready is high only while the sequencer is idle.
// a finished code sits in the output register while the next requests are taken; a
// further code waits in the sequencer until that register is free.
// arst_n clears the hash state to its start values and empties the output register.
module string_id_access_code_hash_top (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [39:0] s_axis_tdata,  // text_byte [7:0], id [39:8]
	input  logic [0:0]  s_axis_tuser,  // has_byte [0]
	input  logic        s_axis_tlast,
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	output logic [31:0] m_axis_tdata   // access_code [31:0]
);

	sidach_pkg::mul_req_t mul_req;
	sidach_pkg::word_t    mul_p;
	sidach_pkg::word_t    code;
	logic                 idle;
	logic                 done;
	logic                 start;
	logic                 out_free;
	logic                 out_valid_q;
	sidach_pkg::word_t    out_data_q;

	assign start    = s_axis_tvalid && idle;
	assign out_free = !out_valid_q || m_axis_tready;

	sidach_seq u_seq (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (start),
		.text_byte (s_axis_tdata[7:0]),
		.has_byte  (s_axis_tuser[0]),
		.last      (s_axis_tlast),
		.id        (s_axis_tdata[39:8]),
		.out_free  (out_free),
		.mul_p     (mul_p),
		.mul_req   (mul_req),
		.idle      (idle),
		.done      (done),
		.code      (code)
	);

	sidach_mul u_mul (
		.clk (clk),
		.req (mul_req),
		.p   (mul_p)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (done) begin
			out_valid_q <= 1'b1;
		end else if (m_axis_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (done) begin
			out_data_q <= code;
		end
	end

	assign s_axis_tready = idle;
	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = out_data_q;

endmodule

// ----- sv/sidach_checker.sv -----
// port-level checks for the access code hash top level, bound to it below
// depends on string_id_access_code_hash_top
module sidach_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        s_axis_tvalid,
	input logic        s_axis_tready,
	input logic [0:0]  s_axis_tuser,
	input logic        s_axis_tlast,
	input logic        m_axis_tvalid,
	input logic        m_axis_tready,
	input logic [31:0] m_axis_tdata
);

	// stalled code holds
	assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
		else $error("stalled code changed");

	// a request with work makes the block busy
	assert property (@(posedge clk) disable iff (!arst_n)
		s_axis_tvalid && s_axis_tready && (s_axis_tuser[0] || s_axis_tlast)
		|=> !s_axis_tready)
		else $error("not busy after a working request");

	// an empty request leaves the block ready
	assert property (@(posedge clk) disable iff (!arst_n)
		s_axis_tvalid && s_axis_tready && !s_axis_tuser[0] && !s_axis_tlast
		|=> s_axis_tready)
		else $error("busy after an empty request");

	// a new code comes only out of a busy period
	assert property (@(posedge clk) disable iff (!arst_n)
		$rose(m_axis_tvalid) |-> $past(!s_axis_tready))
		else $error("code appeared while idle");

endmodule

bind string_id_access_code_hash_top sidach_checker u_sidach_checker (
	.clk           (clk),
	.arst_n        (arst_n),
	.s_axis_tvalid (s_axis_tvalid),
	.s_axis_tready (s_axis_tready),
	.s_axis_tuser  (s_axis_tuser),
	.s_axis_tlast  (s_axis_tlast),
	.m_axis_tvalid (m_axis_tvalid),
	.m_axis_tready (m_axis_tready),
	.m_axis_tdata  (m_axis_tdata)
);
